/* rtl/core/urb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART ring buffers package
// Shared types, codes and default sizes for the receive/transmit ring block.
// ----------------------------------------------------------------------------
package urb_pkg;

	localparam int DEF_RX_DEPTH = 16;
	localparam int DEF_TX_DEPTH = 16;
	localparam int BYTE_W       = 8;
	localparam int KIND_W       = 3;
	localparam int RXC_W        = 4;

	typedef enum logic [KIND_W-1:0] {
		KIND_RX_BYTE = 3'd0,
		KIND_TX_RDY  = 3'd1,
		KIND_GETC    = 3'd2,
		KIND_PEEK    = 3'd3,
		KIND_PUTC    = 3'd4,
		KIND_FLUSH   = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_EXEC = 2'd1,
		ST_RESP = 2'd2
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic rx_push;
		logic rx_overrun;
		logic rx_read;
		logic rx_pop;
		logic no_data;
		logic tx_pop;
		logic tx_stop;
		logic tx_push;
		logic tx_reject;
		logic flush;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		kind_t kind;
		logic  rx_empty;
		logic  rx_full;
		logic  tx_empty;
		logic  tx_full;
	} status_t;

endpackage

/* rtl/core/urb_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module urb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/urb_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART ring buffers controller
// Sequences each item through accept, execute and result, and decodes the
// item kind against the ring status into datapath commands.
// ----------------------------------------------------------------------------
module urb_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  urb_pkg::status_t status,
	output urb_pkg::cmd_t    cmd,
	output logic             busy,
	output logic             done
);

	urb_pkg::state_t state_q;
	urb_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= urb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b0;
		done    = 1'b0;
		case (state_q)
			urb_pkg::ST_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = urb_pkg::ST_EXEC;
				end
			end
			urb_pkg::ST_EXEC: begin
				busy    = 1'b1;
				state_d = urb_pkg::ST_RESP;
				case (status.kind)
					urb_pkg::KIND_RX_BYTE: begin
						if (status.rx_full) begin
							cmd.rx_overrun = 1'b1;
						end else begin
							cmd.rx_push = 1'b1;
						end
					end
					urb_pkg::KIND_TX_RDY: begin
						if (status.tx_empty) begin
							cmd.tx_stop = 1'b1;
						end else begin
							cmd.tx_pop = 1'b1;
						end
					end
					urb_pkg::KIND_GETC: begin
						if (status.rx_empty) begin
							cmd.no_data = 1'b1;
						end else begin
							cmd.rx_read = 1'b1;
							cmd.rx_pop  = 1'b1;
						end
					end
					urb_pkg::KIND_PEEK: begin
						if (status.rx_empty) begin
							cmd.no_data = 1'b1;
						end else begin
							cmd.rx_read = 1'b1;
						end
					end
					urb_pkg::KIND_PUTC: begin
						if (status.tx_full) begin
							cmd.tx_reject = 1'b1;
						end else begin
							cmd.tx_push = 1'b1;
						end
					end
					urb_pkg::KIND_FLUSH: begin
						cmd.flush = 1'b1;
					end
					default: begin
					end
				endcase
			end
			urb_pkg::ST_RESP: begin
				done = 1'b1;
				// The next item may be taken while this result is shown.
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = urb_pkg::ST_EXEC;
				end else begin
					state_d = urb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = urb_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

/* rtl/core/urb_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART ring buffers datapath
// Ring pointers, flags, result registers and the two byte stores.
// ----------------------------------------------------------------------------
module urb_dp #(
	parameter int RX_DEPTH = urb_pkg::DEF_RX_DEPTH,
	parameter int TX_DEPTH = urb_pkg::DEF_TX_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  urb_pkg::cmd_t               cmd,
	output urb_pkg::status_t            status,
	input  logic [urb_pkg::KIND_W-1:0]  kind,
	input  logic [urb_pkg::BYTE_W-1:0]  byte_in,
	output logic [urb_pkg::BYTE_W-1:0]  byte_out,
	output logic                        byte_out_valid,
	output logic                        no_data,
	output logic                        overrun_flag,
	output logic [urb_pkg::BYTE_W-1:0]  tx_byte,
	output logic                        tx_byte_valid,
	output logic                        tx_rejected,
	output logic                        tx_active,
	output logic [urb_pkg::RXC_W-1:0]   rx_count
);

	localparam int RXP_W = $clog2(RX_DEPTH);
	localparam int TXP_W = $clog2(TX_DEPTH);
	localparam int CNT_W = (RXP_W + 1 > urb_pkg::RXC_W) ? RXP_W + 1 : urb_pkg::RXC_W;

	logic [RXP_W-1:0] rx_head_q, rx_tail_q, rx_head_nxt, rx_tail_nxt;
	logic [TXP_W-1:0] tx_head_q, tx_tail_q, tx_head_nxt, tx_tail_nxt;
	logic             overrun_q;
	logic             tx_en_q;
	urb_pkg::kind_t   kind_q;
	logic [urb_pkg::BYTE_W-1:0] byte_q;
	logic             rd_valid_q, no_data_q, txb_valid_q, reject_q;
	logic [urb_pkg::BYTE_W-1:0] rx_rdata, tx_rdata;
	logic [CNT_W-1:0] head_x, tail_x, count;

	assign rx_head_nxt = (rx_head_q == RXP_W'(RX_DEPTH - 1)) ? '0 : rx_head_q + 1'b1;
	assign rx_tail_nxt = (rx_tail_q == RXP_W'(RX_DEPTH - 1)) ? '0 : rx_tail_q + 1'b1;
	assign tx_head_nxt = (tx_head_q == TXP_W'(TX_DEPTH - 1)) ? '0 : tx_head_q + 1'b1;
	assign tx_tail_nxt = (tx_tail_q == TXP_W'(TX_DEPTH - 1)) ? '0 : tx_tail_q + 1'b1;

	assign status.kind     = kind_q;
	assign status.rx_empty = (rx_head_q == rx_tail_q);
	assign status.rx_full  = (rx_head_nxt == rx_tail_q);
	assign status.tx_empty = (tx_head_q == tx_tail_q);
	assign status.tx_full  = (tx_head_nxt == tx_tail_q);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= urb_pkg::kind_t'(kind);
			byte_q <= byte_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_head_q   <= '0;
			rx_tail_q   <= '0;
			tx_head_q   <= '0;
			tx_tail_q   <= '0;
			overrun_q   <= 1'b0;
			tx_en_q     <= 1'b0;
			rd_valid_q  <= 1'b0;
			no_data_q   <= 1'b0;
			txb_valid_q <= 1'b0;
			reject_q    <= 1'b0;
		end else begin
			if (cmd.capture) begin
				rd_valid_q  <= 1'b0;
				no_data_q   <= 1'b0;
				txb_valid_q <= 1'b0;
				reject_q    <= 1'b0;
			end
			if (cmd.rx_push) begin
				rx_head_q <= rx_head_nxt;
				overrun_q <= 1'b0;
			end
			if (cmd.rx_overrun) begin
				overrun_q <= 1'b1;
			end
			if (cmd.rx_read) begin
				rd_valid_q <= 1'b1;
			end
			if (cmd.rx_pop) begin
				rx_tail_q <= rx_tail_nxt;
			end
			if (cmd.no_data) begin
				no_data_q <= 1'b1;
			end
			if (cmd.flush) begin
				rx_head_q <= rx_tail_q;
			end
			if (cmd.tx_pop) begin
				tx_tail_q   <= tx_tail_nxt;
				txb_valid_q <= 1'b1;
			end
			if (cmd.tx_stop) begin
				tx_en_q <= 1'b0;
			end
			if (cmd.tx_push) begin
				tx_head_q <= tx_head_nxt;
				tx_en_q   <= 1'b1;
			end
			if (cmd.tx_reject) begin
				reject_q <= 1'b1;
			end
		end
	end

	urb_ram #(
		.WIDTH(urb_pkg::BYTE_W),
		.DEPTH(RX_DEPTH)
	) u_rx_ram (
		.clk  (clk),
		.we   (cmd.rx_push),
		.waddr(rx_head_nxt),
		.wdata(byte_q),
		.re   (cmd.rx_read),
		.raddr(rx_tail_nxt),
		.rdata(rx_rdata)
	);

	urb_ram #(
		.WIDTH(urb_pkg::BYTE_W),
		.DEPTH(TX_DEPTH)
	) u_tx_ram (
		.clk  (clk),
		.we   (cmd.tx_push),
		.waddr(tx_head_nxt),
		.wdata(byte_q),
		.re   (cmd.tx_pop),
		.raddr(tx_tail_nxt),
		.rdata(tx_rdata)
	);

	// Fill level wraps around the ring when the head sits below the tail.
	assign head_x = CNT_W'(rx_head_q);
	assign tail_x = CNT_W'(rx_tail_q);
	assign count  = (head_x >= tail_x) ? head_x - tail_x
	                                   : head_x + CNT_W'(RX_DEPTH) - tail_x;

	assign byte_out       = rd_valid_q ? rx_rdata : '0;
	assign byte_out_valid = rd_valid_q;
	assign no_data        = no_data_q;
	assign overrun_flag   = overrun_q;
	assign tx_byte        = txb_valid_q ? tx_rdata : '0;
	assign tx_byte_valid  = txb_valid_q;
	assign tx_rejected    = reject_q;
	assign tx_active      = tx_en_q;
	assign rx_count       = count[urb_pkg::RXC_W-1:0];

endmodule

/* rtl/core/uart_rx_tx_ring_buffers_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART receive and transmit ring buffers
// Two byte rings with one-slot-free full detection, served one item at a time.
// ----------------------------------------------------------------------------
// An item (kind, byte_in) is taken at a clock edge where start is high and
// busy is low. Kinds: received byte, transmitter ready, getc, peek, putc and
// flush of the receive ring. Each item gives exactly one result.
// The cycle after acceptance the controller decodes the item, moves the ring
// pointers and reads or writes the ring memory; the memory read is registered,
// so the result appears the following cycle with done high for one cycle.
// A new item may be started in the done cycle; while an item executes, busy
// is high and no new item is taken.
// Results cannot be held off by the receiver: done lasts exactly one cycle.
// Reset empties both rings, clears the overrun and transmit-active flags and
// leaves the ring memories uninitialized; a ring of depth D holds D-1 bytes.
// ----------------------------------------------------------------------------
module uart_rx_tx_ring_buffers_unit #(
	parameter int RX_DEPTH = urb_pkg::DEF_RX_DEPTH,
	parameter int TX_DEPTH = urb_pkg::DEF_TX_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [urb_pkg::KIND_W-1:0]  kind,
	input  logic [urb_pkg::BYTE_W-1:0]  byte_in,
	output logic                        done,
	output logic [urb_pkg::BYTE_W-1:0]  byte_out,
	output logic                        byte_out_valid,
	output logic                        no_data,
	output logic                        overrun_flag,
	output logic [urb_pkg::BYTE_W-1:0]  tx_byte,
	output logic                        tx_byte_valid,
	output logic                        tx_rejected,
	output logic                        tx_active,
	output logic [urb_pkg::RXC_W-1:0]   rx_count
);

	urb_pkg::cmd_t    cmd;
	urb_pkg::status_t status;

	urb_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.status(status),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	urb_dp #(
		.RX_DEPTH(RX_DEPTH),
		.TX_DEPTH(TX_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.kind          (kind),
		.byte_in       (byte_in),
		.byte_out      (byte_out),
		.byte_out_valid(byte_out_valid),
		.no_data       (no_data),
		.overrun_flag  (overrun_flag),
		.tx_byte       (tx_byte),
		.tx_byte_valid (tx_byte_valid),
		.tx_rejected   (tx_rejected),
		.tx_active     (tx_active),
		.rx_count      (rx_count)
	);

endmodule

/* sim/tb_uart_rx_tx_ring_buffers_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART ring buffers testbench
// Drives receive, transmit, getc, peek, putc and flush items into the ring
// block, predicts every result with an independent model of both rings and
// checks each done strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_uart_rx_tx_ring_buffers_unit;

	localparam int RX_D        = urb_pkg::DEF_RX_DEPTH;
	localparam int TX_D        = urb_pkg::DEF_TX_DEPTH;
	localparam int STALL_LIMIT = 200;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [urb_pkg::BYTE_W-1:0] byte_out;
		logic                       byte_out_valid;
		logic                       no_data;
		logic                       overrun_flag;
		logic [urb_pkg::BYTE_W-1:0] tx_byte;
		logic                       tx_byte_valid;
		logic                       tx_rejected;
		logic                       tx_active;
		logic [urb_pkg::RXC_W-1:0]  rx_count;
	} ring_result_t;

	logic                       clk;
	logic                       arst_n;
	logic                       start;
	logic                       busy;
	logic [urb_pkg::KIND_W-1:0] kind;
	logic [urb_pkg::BYTE_W-1:0] byte_in;
	logic                       done;
	logic [urb_pkg::BYTE_W-1:0] byte_out;
	logic                       byte_out_valid;
	logic                       no_data;
	logic                       overrun_flag;
	logic [urb_pkg::BYTE_W-1:0] tx_byte;
	logic                       tx_byte_valid;
	logic                       tx_rejected;
	logic                       tx_active;
	logic [urb_pkg::RXC_W-1:0]  rx_count;

	// Shadow copy of both rings and the two flags.
	logic [urb_pkg::BYTE_W-1:0] rx_ring [RX_D];
	logic [urb_pkg::BYTE_W-1:0] tx_ring [TX_D];
	int                rx_head = 0;
	int                rx_tail = 0;
	int                tx_head = 0;
	int                tx_tail = 0;
	logic              rx_overrun = 1'b0;
	logic              tx_enabled = 1'b0;

	ring_result_t      ring_expect_q [$];
	ring_result_t      seen_result;
	ring_result_t      want_result;

	int                mismatches = 0;
	int                results_checked = 0;
	int                items_sent = 0;
	int                directed_items = 0;
	int                stall_cycles = 0;
	int                n_overruns = 0;
	int                n_empty_reads = 0;
	int                n_rejects = 0;
	int                n_tx_sent = 0;
	int                n_flushes = 0;
	int                max_rx_fill = 0;

	uart_rx_tx_ring_buffers_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.kind           (kind),
		.byte_in        (byte_in),
		.done           (done),
		.byte_out       (byte_out),
		.byte_out_valid (byte_out_valid),
		.no_data        (no_data),
		.overrun_flag   (overrun_flag),
		.tx_byte        (tx_byte),
		.tx_byte_valid  (tx_byte_valid),
		.tx_rejected    (tx_rejected),
		.tx_active      (tx_active),
		.rx_count       (rx_count)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int ring_next(input int idx, input int depth);
		return (idx + 1 >= depth) ? 0 : idx + 1;
	endfunction

	function automatic string fmt_result(input ring_result_t r);
		return $sformatf("rd=%02h v=%b nd=%b ovr=%b tx=%02h v=%b rej=%b act=%b cnt=%0d",
			r.byte_out, r.byte_out_valid, r.no_data, r.overrun_flag, r.tx_byte,
			r.tx_byte_valid, r.tx_rejected, r.tx_active, r.rx_count);
	endfunction

	// Advances the shadow rings by one accepted item and queues its result.
	task automatic predict_ring_item(input urb_pkg::kind_t k,
			input logic [urb_pkg::BYTE_W-1:0] d);
		ring_result_t r;
		int           nxt;
		int           fill;
		r = '0;
		case (k)
			urb_pkg::KIND_RX_BYTE: begin
				nxt = ring_next(rx_head, RX_D);
				if (nxt == rx_tail) begin
					rx_overrun = 1'b1;
					n_overruns++;
				end else begin
					rx_head = nxt;
					rx_ring[nxt] = d;
					rx_overrun = 1'b0;
				end
			end
			urb_pkg::KIND_TX_RDY: begin
				if (tx_head != tx_tail) begin
					tx_tail = ring_next(tx_tail, TX_D);
					r.tx_byte = tx_ring[tx_tail];
					r.tx_byte_valid = 1'b1;
					n_tx_sent++;
				end else begin
					tx_enabled = 1'b0;
				end
			end
			urb_pkg::KIND_GETC, urb_pkg::KIND_PEEK: begin
				if (rx_head == rx_tail) begin
					r.no_data = 1'b1;
					n_empty_reads++;
				end else begin
					nxt = ring_next(rx_tail, RX_D);
					r.byte_out = rx_ring[nxt];
					r.byte_out_valid = 1'b1;
					if (k == urb_pkg::KIND_GETC)
						rx_tail = nxt;
				end
			end
			urb_pkg::KIND_PUTC: begin
				nxt = ring_next(tx_head, TX_D);
				if (nxt == tx_tail) begin
					r.tx_rejected = 1'b1;
					n_rejects++;
				end else begin
					tx_ring[nxt] = d;
					tx_head = nxt;
					tx_enabled = 1'b1;
				end
			end
			urb_pkg::KIND_FLUSH: begin
				rx_head = rx_tail;
				n_flushes++;
			end
			default: begin
			end
		endcase
		fill = (rx_head + RX_D - rx_tail) % RX_D;
		if (fill > max_rx_fill)
			max_rx_fill = fill;
		r.overrun_flag = rx_overrun;
		r.tx_active = tx_enabled;
		r.rx_count = fill[urb_pkg::RXC_W-1:0];
		ring_expect_q.push_back(r);
	endtask

	// Presents one item from the falling edge and holds it until accepted.
	task automatic send_item(input urb_pkg::kind_t k, input logic [urb_pkg::BYTE_W-1:0] d);
		@(negedge clk);
		start = 1'b1;
		kind = k;
		byte_in = d;
		do @(posedge clk); while (busy);
		predict_ring_item(k, d);
		items_sent++;
	endtask

	// The cycle right after an accept is busy anyway, so start drops there
	// and each later cycle where an item could be taken stays idle with the
	// given chance.
	task automatic sender_pause(input int pct);
		if ($urandom_range(99) < pct) begin
			@(negedge clk);
			start = 1'b0;
			byte_in = 8'($urandom_range(255));
			@(negedge clk);
			while ($urandom_range(99) < pct)
				@(negedge clk);
		end
	endtask

	function automatic urb_pkg::kind_t weighted_kind(input int w_rx, input int w_rdy,
			input int w_get, input int w_peek, input int w_put);
		int pick;
		pick = $urandom_range(99);
		if (pick < w_rx)
			return urb_pkg::KIND_RX_BYTE;
		pick -= w_rx;
		if (pick < w_rdy)
			return urb_pkg::KIND_TX_RDY;
		pick -= w_rdy;
		if (pick < w_get)
			return urb_pkg::KIND_GETC;
		pick -= w_get;
		if (pick < w_peek)
			return urb_pkg::KIND_PEEK;
		pick -= w_peek;
		if (pick < w_put)
			return urb_pkg::KIND_PUTC;
		return urb_pkg::KIND_FLUSH;
	endfunction

	task automatic test_empty_reads();
		send_item(urb_pkg::KIND_GETC, 8'h00);
		send_item(urb_pkg::KIND_PEEK, 8'hFF);
		send_item(urb_pkg::KIND_TX_RDY, 8'h00);
		send_item(urb_pkg::KIND_FLUSH, 8'hFF);
	endtask

	task automatic test_rx_order_and_flush();
		send_item(urb_pkg::KIND_RX_BYTE, 8'h00);
		send_item(urb_pkg::KIND_RX_BYTE, 8'hFF);
		send_item(urb_pkg::KIND_RX_BYTE, 8'hA5);
		send_item(urb_pkg::KIND_PEEK, 8'h00);
		send_item(urb_pkg::KIND_GETC, 8'h00);
		send_item(urb_pkg::KIND_GETC, 8'h00);
		send_item(urb_pkg::KIND_FLUSH, 8'h00);
		send_item(urb_pkg::KIND_GETC, 8'h00);
	endtask

	task automatic test_tx_queue();
		send_item(urb_pkg::KIND_PUTC, 8'h00);
		send_item(urb_pkg::KIND_PUTC, 8'hFF);
		send_item(urb_pkg::KIND_TX_RDY, 8'h00);
		send_item(urb_pkg::KIND_TX_RDY, 8'h00);
		send_item(urb_pkg::KIND_TX_RDY, 8'h00);
		send_item(urb_pkg::KIND_PUTC, 8'h3C);
		send_item(urb_pkg::KIND_TX_RDY, 8'hFF);
	endtask

	// Traffic runs in balanced segments or ones leaning toward filling or
	// draining the rings, so full and empty conditions are reached many times.
	task automatic test_random_traffic(input int n_items, input int idle_pct);
		int                         mode;
		int                         pick;
		urb_pkg::kind_t             k;
		logic [urb_pkg::BYTE_W-1:0] d;
		mode = 0;
		for (int i = 0; i < n_items; i++) begin
			if (i % 40 == 0)
				mode = $urandom_range(2);
			case (mode)
				0: k = weighted_kind(25, 20, 20, 10, 22);
				1: k = weighted_kind(45, 3, 3, 4, 45);
				default: k = weighted_kind(8, 38, 38, 8, 5);
			endcase
			pick = $urandom_range(9);
			if (pick == 0)
				d = 8'h00;
			else if (pick == 1)
				d = 8'hFF;
			else
				d = 8'($urandom_range(255));
			send_item(k, d);
			sender_pause(idle_pct);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			seen_result = {byte_out, byte_out_valid, no_data, overrun_flag, tx_byte,
				tx_byte_valid, tx_rejected, tx_active, rx_count};
			if (ring_expect_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("ERROR: result with nothing pending: %s", fmt_result(seen_result));
			end else begin
				want_result = ring_expect_q.pop_front();
				results_checked++;
				if (seen_result !== want_result) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("ERROR: result %0d expected %s", results_checked,
							fmt_result(want_result));
						$display("       result %0d actual   %s", results_checked,
							fmt_result(seen_result));
					end
				end
			end
		end
	end

	// Ends the run when neither an item nor a result moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Timeout after %0d idle cycles", stall_cycles);
				$display("uart_rx_tx_ring_buffers_unit: mismatch");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		kind = urb_pkg::KIND_RX_BYTE;
		byte_in = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_reads();
		test_rx_order_and_flush();
		test_tx_queue();
		directed_items = items_sent;

		test_random_traffic(184, 13);
		test_random_traffic(184, 61);
		test_random_traffic(184, 0);

		@(negedge clk);
		start = 1'b0;
		while (ring_expect_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		if (ring_expect_q.size() != 0) begin
			mismatches += ring_expect_q.size();
			$display("ERROR: %0d results never arrived", ring_expect_q.size());
		end

		$display("Checked %0d results from %0d items (%0d directed); peak receive fill %0d.",
			results_checked, items_sent, directed_items, max_rx_fill);
		$display("Overruns %0d, empty reads %0d, putc rejects %0d, bytes sent %0d, flushes %0d.",
			n_overruns, n_empty_reads, n_rejects, n_tx_sent, n_flushes);
		if (mismatches == 0) begin
			$display("uart_rx_tx_ring_buffers_unit: match");
		end else begin
			$display("uart_rx_tx_ring_buffers_unit: mismatch");
		end
		$finish;
	end

endmodule
